// ----- rtl/kfd_pkg.sv -----
`default_nettype none

package kfd_pkg;

   // KISS special bytes
   localparam logic [7:0] FEND_CODE  = 8'hC0;
   localparam logic [7:0] FESC_CODE  = 8'hDB;
   localparam logic [7:0] TFEND_CODE = 8'hDC;
   localparam logic [7:0] TFESC_CODE = 8'hDD;
   localparam logic [7:0] RETURN_CMD = 8'hFF;

   // field widths
   localparam int unsigned POS_W     = 12;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned BUFLEN_W  = 13;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 16;

   // largest restart limit, keeps the position within POS_W bits
   localparam logic [POS_W-1:0] MAX_LIMIT = 12'd4094;
   // limit after reset: buffer length 512 minus two
   localparam logic [POS_W-1:0] RESET_LIMIT     = 12'd510;
   localparam logic [TICK_W-1:0] RESET_TIMEOUT  = 16'd2000;
   localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_TIMEOUT  = 1'b1;

   // result kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // input opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // frame actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_DATA    = 3'd1;
   localparam logic [2:0] ACT_SETTING = 3'd2;
   localparam logic [2:0] ACT_EXIT    = 3'd3;
   localparam logic [2:0] ACT_PORT    = 3'd4;
   localparam logic [2:0] ACT_SHORT   = 3'd5;
   localparam logic [2:0] ACT_UNKNOWN = 3'd6;

   // KISS command nibbles
   localparam logic [3:0] CMD_DATA     = 4'd0;
   localparam logic [3:0] CMD_TXDELAY  = 4'd1;
   localparam logic [3:0] CMD_PERSIST  = 4'd2;
   localparam logic [3:0] CMD_SLOTTIME = 4'd3;
   localparam logic [3:0] CMD_TXTAIL   = 4'd4;
   localparam logic [3:0] CMD_DUPLEX   = 4'd5;

   // channel settings
   typedef struct packed {
      logic [7:0] tx_delay;
      logic [7:0] persistence;
      logic [7:0] slot_period;
      logic [7:0] tx_tail;
      logic [7:0] duplex;
   } settings_type;

   localparam settings_type SETTINGS_RESET = '{
      tx_delay:    8'd50,
      persistence: 8'd63,
      slot_period: 8'd10,
      tx_tail:     8'd5,
      duplex:      8'd0
   };

endpackage

`default_nettype wire

// ----- rtl/kfd_cmd_decode.sv -----
`default_nettype none

module kfd_cmd_decode (
   input  wire logic                      enable,
   input  wire logic [kfd_pkg::POS_W-1:0] frame_length,
   input  wire logic [7:0]                first_byte,
   input  wire logic [7:0]                second_byte,
   input  wire kfd_pkg::settings_type     settings_cur,
   output      logic [2:0]                frame_action,
   output      kfd_pkg::settings_type     settings_new
);
   import kfd_pkg::*;

   logic [3:0] cmd;
   logic [3:0] port;
   logic       param_nz;

   assign cmd      = first_byte[3:0];
   assign port     = first_byte[7:4];
   assign param_nz = (second_byte != 8'd0);

   // classify the frame and apply setting commands
   always_comb begin
      settings_new = settings_cur;
      frame_action = ACT_NONE;
      if (enable) begin
         if (frame_length == POS_W'(1) && first_byte == RETURN_CMD) begin
            frame_action = ACT_EXIT;
         end else if (port != 4'd0) begin
            frame_action = ACT_PORT;
         end else if (frame_length < POS_W'(2)) begin
            frame_action = ACT_SHORT;
         end else begin
            case (cmd)
               CMD_DATA: begin
                  frame_action = ACT_DATA;
               end
               CMD_TXDELAY: begin
                  frame_action = ACT_SETTING;
                  if (param_nz) settings_new.tx_delay = second_byte;
               end
               CMD_PERSIST: begin
                  frame_action = ACT_SETTING;
                  if (param_nz) settings_new.persistence = second_byte;
               end
               CMD_SLOTTIME: begin
                  frame_action = ACT_SETTING;
                  if (param_nz) settings_new.slot_period = second_byte;
               end
               CMD_TXTAIL: begin
                  frame_action = ACT_SETTING;
                  if (param_nz) settings_new.tx_tail = second_byte;
               end
               CMD_DUPLEX: begin
                  frame_action = ACT_SETTING;
                  settings_new.duplex = second_byte;
               end
               default: begin
                  frame_action = ACT_UNKNOWN;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kiss_frame_deframer.sv -----
`default_nettype none
// Path: a word accepted on req_ is held in the input register, and its result
//    is then written to the result register, which drives rsp_.
// Throughput: one word per cycle while the result register has room; bytes, ticks and frame ends all take one pass.
// Reset (synchronous, active high) empties both registers, clears position,
//    escape, idle count and restart flag, and loads the default settings.

module kiss_frame_deframer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input words
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [7:0]                    req_rx_byte,
   // results
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_kind,
   output      logic [7:0]                    rsp_data_byte,
   output      logic [kfd_pkg::POS_W-1:0]     rsp_byte_index,
   output      logic                          rsp_restarted,
   output      logic [2:0]                    rsp_frame_action,
   output      logic [kfd_pkg::POS_W-1:0]     rsp_frame_length,
   output      logic [7:0]                    rsp_tx_delay_out,
   output      logic [7:0]                    rsp_persistence_out,
   output      logic [7:0]                    rsp_slot_time_out,
   output      logic [7:0]                    rsp_tx_tail_out,
   output      logic [7:0]                    rsp_duplex_out,
   // configuration writes
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [kfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [kfd_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import kfd_pkg::*;

   // configuration
   logic [POS_W-1:0]    limit_ff;
   logic [TICK_W-1:0]   timeout_ff;
   logic [BUFLEN_W-1:0] buf_len;
   logic [POS_W-1:0]    limit_in;

   // input register
   logic       in_valid_ff;
   logic       in_opcode_ff;
   logic [7:0] in_byte_ff;

   // frame state
   logic [POS_W-1:0]  pos_ff,     pos_in;
   logic              esc_ff,     esc_in;
   logic [TICK_W-1:0] idle_ff,    idle_in;
   logic              restart_ff, restart_in;
   logic [7:0]        first_ff,   first_in;
   logic [7:0]        second_ff,  second_in;
   settings_type      set_ff,     set_in;

   // result register
   logic             out_valid_ff;
   logic             out_kind_ff;
   logic [7:0]       out_data_ff;
   logic [POS_W-1:0] out_index_ff;
   logic             out_restart_ff;
   logic [2:0]       out_action_ff;
   logic [POS_W-1:0] out_length_ff;
   settings_type     out_set_ff;

   // pass logic
   logic             is_tick, is_fend, is_fesc, has_result;
   logic             pos_nz, drop, restart_now;
   logic [POS_W-1:0] pos_eff;
   logic [7:0]       plain_byte;
   logic             out_free, proc_fire;
   logic [2:0]       dec_action;
   settings_type     dec_set;

   // restart limit: buffer length minus two, floored at zero, capped
   assign buf_len = csr_wdata[BUFLEN_W-1:0];
   always_comb begin
      if (buf_len < BUFLEN_W'(2)) begin
         limit_in = '0;
      end else if (buf_len - BUFLEN_W'(2) > BUFLEN_W'(MAX_LIMIT)) begin
         limit_in = MAX_LIMIT;
      end else begin
         limit_in = POS_W'(buf_len - BUFLEN_W'(2));
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= RESET_LIMIT;
         timeout_ff <= RESET_TIMEOUT;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BUFFER_LENGTH: limit_ff   <= limit_in;
            REG_IDLE_TIMEOUT:  timeout_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // decode the held word
   assign is_tick    = (in_opcode_ff == OP_TICK);
   assign is_fend    = !is_tick && (in_byte_ff == FEND_CODE);
   assign is_fesc    = !is_tick && (in_byte_ff == FESC_CODE);
   assign has_result = !is_tick && !is_fesc;

   // drop a stale or overflowing partial frame before this byte
   assign pos_nz      = (pos_ff != '0);
   assign drop        = (pos_nz && idle_ff > timeout_ff) || (pos_ff >= limit_ff);
   assign pos_eff     = drop ? '0 : pos_ff;
   assign restart_now = restart_ff || (pos_nz && drop);

   // undo the escape
   always_comb begin
      plain_byte = in_byte_ff;
      if (esc_ff && in_byte_ff == TFESC_CODE) plain_byte = FESC_CODE;
      if (esc_ff && in_byte_ff == TFEND_CODE) plain_byte = FEND_CODE;
   end

   kfd_cmd_decode u_cmd_decode (
      .enable       (!esc_ff && pos_eff != '0),
      .frame_length (pos_eff),
      .first_byte   (first_ff),
      .second_byte  (second_ff),
      .settings_cur (set_ff),
      .frame_action (dec_action),
      .settings_new (dec_set)
   );

   // handshake: advance the held word when its result has room
   assign out_free  = !out_valid_ff || rsp_ready;
   assign proc_fire = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || proc_fire;

   // next frame state
   always_comb begin
      pos_in     = pos_ff;
      esc_in     = esc_ff;
      idle_in    = idle_ff;
      restart_in = restart_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      set_in     = set_ff;
      if (is_tick) begin
         if (idle_ff != TICK_MAX) idle_in = idle_ff + TICK_W'(1);
      end else if (is_fend) begin
         pos_in     = '0;
         esc_in     = 1'b0;
         restart_in = 1'b0;
         set_in     = dec_set;
      end else if (is_fesc) begin
         pos_in     = pos_eff;
         esc_in     = 1'b1;
         restart_in = restart_now;
      end else begin
         pos_in     = pos_eff + POS_W'(1);
         esc_in     = 1'b0;
         idle_in    = '0;
         restart_in = 1'b0;
         if (pos_eff == POS_W'(0)) first_in  = plain_byte;
         if (pos_eff == POS_W'(1)) second_in = plain_byte;
      end
   end

   // hold the input word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_opcode_ff <= req_opcode;
         in_byte_ff   <= req_rx_byte;
      end
   end

   // update the frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         esc_ff     <= 1'b0;
         idle_ff    <= '0;
         restart_ff <= 1'b0;
         set_ff     <= SETTINGS_RESET;
      end else if (proc_fire) begin
         pos_ff     <= pos_in;
         esc_ff     <= esc_in;
         idle_ff    <= idle_in;
         restart_ff <= restart_in;
         set_ff     <= set_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_fire && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && has_result) begin
         out_kind_ff    <= is_fend ? KIND_REPORT : KIND_BYTE;
         out_data_ff    <= is_fend ? 8'd0 : plain_byte;
         out_index_ff   <= is_fend ? '0 : pos_eff;
         out_restart_ff <= restart_now;
         out_action_ff  <= is_fend ? dec_action : ACT_NONE;
         out_length_ff  <= is_fend ? pos_eff : '0;
         out_set_ff     <= set_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_kind_ff;
   assign rsp_data_byte       = out_data_ff;
   assign rsp_byte_index      = out_index_ff;
   assign rsp_restarted       = out_restart_ff;
   assign rsp_frame_action    = out_action_ff;
   assign rsp_frame_length    = out_length_ff;
   assign rsp_tx_delay_out    = out_set_ff.tx_delay;
   assign rsp_persistence_out = out_set_ff.persistence;
   assign rsp_slot_time_out   = out_set_ff.slot_period;
   assign rsp_tx_tail_out     = out_set_ff.tx_tail;
   assign rsp_duplex_out      = out_set_ff.duplex;

endmodule

`default_nettype wire
